### hdl/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared constants and types for the CRC checked frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int unsigned STORE_BYTES = 32;
  localparam int unsigned STORE_AW    = $clog2(STORE_BYTES);
  localparam int unsigned LEN_W       = STORE_AW;
  localparam int unsigned CNT_W       = $clog2(STORE_BYTES + 1);

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CRC_W       = 16;
  localparam int unsigned BITCNT_W    = 4;

  localparam logic [BYTE_W-1:0]    HDR_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0]    HDR_SECOND = 8'hAA;
  localparam logic [CRC_W-1:0]     CRC_INIT   = 16'hFFFF;
  localparam logic [CRC_W-1:0]     CRC_POLY   = 16'hA001;
  localparam logic [BITCNT_W-1:0]  CRC_BITS   = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID_LOW  = 1'b1;

  typedef struct packed {
    logic              feed;
    logic              init;
    logic [BYTE_W-1:0] data;
  } crc_ctrl_t;

endpackage

### hdl/cfp_stream_if.sv
// ----------------------------------------------------------------------------
// cfp_stream_if
// Valid/ready channels for received bytes and for emitted frame bytes.
// ----------------------------------------------------------------------------
interface cfp_rx_if import cfp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_frame_if import cfp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic [IDX_W-1:0]  byte_index;
  logic              last;

  modport source (output valid, output frame_byte, output byte_index, output last,
                  input ready);
  modport sink   (input valid, input frame_byte, input byte_index, input last,
                  output ready);
endinterface

### hdl/crc_checked_frame_parser_core.sv
// ----------------------------------------------------------------------------
// crc_checked_frame_parser_core
// Hunts 0x55 0xAA headers, checks device id and CRC-16/MODBUS, and emits the
// id, command and payload bytes of every good frame.
// ----------------------------------------------------------------------------
//  channel   dir  beat fields
//  rx_i      in   rx_byte
//  frame_o   out  frame_byte, byte_index, last
//  cfg_*     in   cfg_idx_i, cfg_data_i (write on cfg_we_i)
//
// a byte that enters the crc holds rx ready low while the serial crc steps
// through its bits; a good frame of length n then emits n bytes, each a frame
// store read then an output register load, one read in flight at a time, rx
// ready held low until the last read is issued. reset puts the parser in
// header hunt, the store needs no clearing. a frame_o stall holds the output
// register and pauses store reads, so rx ready stays low longer during an emit.
// ----------------------------------------------------------------------------
module crc_checked_frame_parser_core import cfp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  cfp_rx_if.sink               rx_i,
  cfp_frame_if.source          frame_o
);

  localparam logic [2:0] ST_HDR1 = 3'd0;
  localparam logic [2:0] ST_HDR2 = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_IDH  = 3'd3;
  localparam logic [2:0] ST_IDL  = 3'd4;
  localparam logic [2:0] ST_CMD  = 3'd5;
  localparam logic [2:0] ST_BODY = 3'd6;
  localparam logic [2:0] ST_CRCL = 3'd7;

  localparam logic [BYTE_W:0] LEN_LIMIT = (BYTE_W+1)'(STORE_BYTES);

  logic [BYTE_W-1:0] id_high_q, id_low_q;
  logic [2:0]        step_q, step_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0] crc_hi_q, crc_hi_d;

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic              store_en;
  logic [STORE_AW-1:0] wr_addr;
  logic              in_crc;
  logic              emit_start;
  crc_ctrl_t         crc_ctrl;
  logic              crc_busy;
  logic [CRC_W-1:0]  crc_val;

  // emit path
  logic              emit_q;
  logic [LEN_W-1:0]  k_q;
  logic              issue;
  logic              issue_last;
  logic              rd_pend_q;
  logic [IDX_W-1:0]  pend_idx_q;
  logic              pend_last_q;
  logic [BYTE_W-1:0] rd_data;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_last_q;

  assign b            = rx_i.rx_byte;
  assign rx_i.ready   = !emit_q && !crc_busy;
  assign accept       = rx_i.valid && rx_i.ready;
  assign in_crc       = (count_q <= CNT_W'(len_q));

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_high_q <= '0;
      id_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEVICE_ID_HIGH: id_high_q <= cfg_data_i;
        CFG_DEVICE_ID_LOW:  id_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parser
  always_comb begin
    step_d        = step_q;
    len_d         = len_q;
    count_d       = count_q;
    crc_hi_d      = crc_hi_q;
    store_en      = 1'b0;
    wr_addr       = count_q[STORE_AW-1:0];
    emit_start    = 1'b0;
    crc_ctrl.feed = 1'b0;
    crc_ctrl.init = 1'b0;
    crc_ctrl.data = b;
    if (accept) begin
      case (step_q)
        ST_HDR1: begin
          if (b == HDR_FIRST) begin
            step_d = ST_HDR2;
          end
        end
        ST_HDR2: begin
          step_d = (b == HDR_SECOND) ? ST_LEN : ST_HDR1;
        end
        ST_LEN: begin
          if ({1'b0, b} >= LEN_LIMIT) begin
            step_d = ST_HDR1;
          end else begin
            len_d         = b[LEN_W-1:0];
            count_d       = CNT_W'(1);
            store_en      = 1'b1;
            wr_addr       = '0;
            crc_ctrl.feed = 1'b1;
            crc_ctrl.init = 1'b1;
            step_d        = ST_IDH;
          end
        end
        ST_IDH: begin
          if (b == id_high_q) begin
            store_en      = 1'b1;
            crc_ctrl.feed = in_crc;
            count_d       = count_q + 1'b1;
            step_d        = ST_IDL;
          end else begin
            step_d = ST_HDR1;
          end
        end
        ST_IDL: begin
          if (b == id_low_q) begin
            store_en      = 1'b1;
            crc_ctrl.feed = in_crc;
            count_d       = count_q + 1'b1;
            step_d        = ST_CMD;
          end else begin
            step_d = ST_HDR1;
          end
        end
        ST_CMD: begin
          store_en      = 1'b1;
          crc_ctrl.feed = in_crc;
          count_d       = count_q + 1'b1;
          step_d        = ST_BODY;
        end
        ST_BODY: begin
          if (in_crc) begin
            store_en      = 1'b1;
            crc_ctrl.feed = 1'b1;
            count_d       = count_q + 1'b1;
          end else begin
            crc_hi_d = b;
            step_d   = ST_CRCL;
          end
        end
        ST_CRCL: begin
          emit_start = ({crc_hi_q, b} == crc_val) && (len_q != '0);
          step_d     = ST_HDR1;
        end
        default: begin
          step_d = ST_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= ST_HDR1;
      len_q    <= '0;
      count_q  <= '0;
      crc_hi_q <= '0;
    end else begin
      step_q   <= step_d;
      len_q    <= len_d;
      count_q  <= count_d;
      crc_hi_q <= crc_hi_d;
    end
  end

  cfp_crc_serial u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .busy_o (crc_busy),
    .crc_o  (crc_val)
  );

  // frame store
  assign issue      = emit_q && !rd_pend_q && (!out_valid_q || frame_o.ready);
  assign issue_last = (LEN_W'(k_q + 1'b1) == len_q);

  cfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (wr_addr),
    .wdata_i (b),
    .re_i    (issue),
    .raddr_i (STORE_AW'(k_q + 1'b1)),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q      <= 1'b0;
      k_q         <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_start) begin
        emit_q <= 1'b1;
        k_q    <= '0;
      end else if (issue) begin
        k_q <= k_q + 1'b1;
        if (issue_last) begin
          emit_q <= 1'b0;
        end
      end
      rd_pend_q <= issue;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (frame_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_idx_q  <= IDX_W'(k_q);
      pend_last_q <= issue_last;
    end
    if (rd_pend_q) begin
      out_byte_q <= rd_data;
      out_idx_q  <= pend_idx_q;
      out_last_q <= pend_last_q;
    end
  end

  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.byte_index = out_idx_q;
  assign frame_o.last       = out_last_q;

endmodule

### hdl/cfp_ram.sv
// ----------------------------------------------------------------------------
// cfp_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module cfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/cfp_crc_serial.sv
// ----------------------------------------------------------------------------
// cfp_crc_serial
// Bit-serial CRC-16/MODBUS: one data bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module cfp_crc_serial import cfp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  crc_ctrl_t        ctrl_i,
  output logic             busy_o,
  output logic [CRC_W-1:0] crc_o
);

  logic [CRC_W-1:0]    crc_q, crc_d;
  logic [BYTE_W-1:0]   sh_q, sh_d;
  logic [BITCNT_W-1:0] cnt_q, cnt_d;
  logic                fb;

  assign fb = crc_q[0] ^ sh_q[0];

  always_comb begin
    crc_d = crc_q;
    sh_d  = sh_q;
    cnt_d = cnt_q;
    if (ctrl_i.feed) begin
      sh_d  = ctrl_i.data;
      cnt_d = CRC_BITS;
      if (ctrl_i.init) begin
        crc_d = CRC_INIT;
      end
    end else if (cnt_q != '0) begin
      crc_d = {1'b0, crc_q[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
      sh_d  = {1'b0, sh_q[BYTE_W-1:1]};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
      cnt_q <= '0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign busy_o = (cnt_q != '0);
  assign crc_o  = crc_q;

endmodule
